### rtl/enb_pkg.sv
// ----------------------------------------------------------------------------
// enb_pkg: shared types and constants of the eight-neighbor blur
// word layouts of the pixel and result channels, register indexes, defaults
// ----------------------------------------------------------------------------
package enb_pkg;

   // default line store depth and frame height limit
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   // configuration registers
   localparam int CFG_W = 12;
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

   // field widths
   localparam int CHAN_W = 8;
   localparam int PIX_W  = 3 * CHAN_W;
   localparam int POS_W  = 11;

   // result queue, depth must be a power of two
   localparam int OUT_FIFO_DEPTH = 8;

   typedef struct packed {
      logic [CHAN_W-1:0] in_red;
      logic [CHAN_W-1:0] in_green;
      logic [CHAN_W-1:0] in_blue;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_red;
      logic [CHAN_W-1:0] out_green;
      logic [CHAN_W-1:0] out_blue;
      logic [POS_W-1:0]  out_row;
      logic [POS_W-1:0]  out_col;
      logic              last_of_run;
   } rsp_type;

   // up to two result words entering the queue in one cycle, word0 first
   typedef struct packed {
      logic [1:0] num;
      rsp_type    word0;
      rsp_type    word1;
   } enb_push_type;

endpackage

### rtl/enb_ram.sv
// ----------------------------------------------------------------------------
// enb_ram: generic single-port-write, single-port-read ram
// one write and one registered read per cycle, read returns the old data
// ----------------------------------------------------------------------------
module enb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/enb_out_fifo.sv
// ----------------------------------------------------------------------------
// enb_out_fifo: result word queue
// takes up to two words a cycle in order, hands out one word a cycle
// ----------------------------------------------------------------------------
module enb_out_fifo
   import enb_pkg::*;
#(
   parameter int DEPTH = OUT_FIFO_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  enb_push_type push,
   input  logic         pop,
   output logic         out_valid,
   output rsp_type      out_word
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   rsp_type         mem_ff [DEPTH];
   logic [PW-1:0]   head_ff, head_in;
   logic [PW-1:0]   tail_ff, tail_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [PW-1:0]   tail_next;

   // pointer and occupancy update
   always_comb begin
      tail_next = tail_ff + PW'(1);
      head_in   = pop ? head_ff + PW'(1) : head_ff;
      tail_in   = tail_ff + PW'(push.num);
      count_in  = count_ff + CW'(push.num) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         mem_ff[tail_ff] <= push.word0;
      end
      if (push.num == 2'd2) begin
         mem_ff[tail_next] <= push.word1;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_word  = mem_ff[head_ff];

endmodule

### rtl/eight_neighbor_blur_top.sv
// ----------------------------------------------------------------------------
// eight_neighbor_blur_top: streaming 3x3 neighbor mean over rgb pixels
// border pixels pass through, interior pixels become the sum of their eight
// neighbors each divided by 8; one 48-bit line memory holds the two rows above
// ----------------------------------------------------------------------------
//  channel   direction  handshake            word
//  req_*     in         req_valid/req_stall  req_type: one raster-order pixel
//  rsp_*     out        rsp_valid/rsp_stall  rsp_type: pixel, row, col, last
//  csr_*     in         csr_valid/csr_ready  csr_index, csr_wdata (12 bit)
//
//  one pixel per cycle is taken unless req_stall is high; the line memory is read
//  at accept and written back in the cycle after, forwarding a same-column write
//  results reach the queue from stage two; the queue drains one word per cycle
//  unless rsp_stall; two-result pixels (last row or column) throttle the input
//  req_stall rises when the queue plus words in flight could not take two more
//  synchronous reset clears counters, window and queue; no memory clearing pass
// ----------------------------------------------------------------------------
module eight_neighbor_blur_top
   import enb_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic             csr_index,
   input  logic [CFG_W-1:0] csr_wdata
);

   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int XE   = $clog2(MAX_WIDTH + 1);
   localparam int YE   = $clog2(MAX_HEIGHT + 1);
   localparam int WA   = (XE > YE) ? XE : YE;
   localparam int WW   = (WA > CFG_W) ? WA : CFG_W;
   localparam int QCW  = $clog2(OUT_FIFO_DEPTH + 1);

   // configuration registers
   logic [CFG_W-1:0] frame_width_ff;
   logic [CFG_W-1:0] frame_height_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // effective frame size, zero taken as one, capped at the maximum
   logic [WW-1:0] w_raw, h_raw, w_eff, h_eff;

   always_comb begin
      w_raw = WW'(frame_width_ff);
      h_raw = WW'(frame_height_ff);
      if (w_raw == '0) w_eff = WW'(1);
      else if (w_raw > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
      else w_eff = w_raw;
      if (h_raw == '0) h_eff = WW'(1);
      else if (h_raw > WW'(MAX_HEIGHT)) h_eff = WW'(MAX_HEIGHT);
      else h_eff = h_raw;
   end

   // position of the arriving pixel
   logic [XW-1:0] col_ff, col_in;
   logic [YW-1:0] row_ff, row_in;
   logic [WW-1:0] c_cur, r_tmp, r_cur;
   logic          wrap_col, last_col, is_interior, is_border;
   logic [1:0]    n_words;
   logic          accept;

   assign accept = req_valid && !req_stall;

   always_comb begin
      wrap_col    = WW'(col_ff) >= w_eff;
      c_cur       = wrap_col ? '0 : WW'(col_ff);
      r_tmp       = wrap_col ? WW'(row_ff) + WW'(1) : WW'(row_ff);
      r_cur       = (r_tmp >= h_eff) ? '0 : r_tmp;
      is_interior = (r_cur >= WW'(2)) && (c_cur >= WW'(2));
      is_border   = (r_cur == '0) || (r_cur == h_eff - WW'(1)) ||
                    (c_cur == '0) || (c_cur == w_eff - WW'(1));
      n_words     = 2'(is_interior) + 2'(is_border);
      last_col    = (c_cur + WW'(1)) >= w_eff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = ((r_cur + WW'(1)) >= h_eff) ? '0 : YW'(r_cur + WW'(1));
         end else begin
            col_in = XW'(c_cur + WW'(1));
            row_in = YW'(r_cur);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line memory: {row above, row two above} per column
   logic                 ram_wr_en;
   logic [XW-1:0]        ram_wr_addr;
   logic [2*PIX_W-1:0]   ram_wr_data;
   logic [2*PIX_W-1:0]   ram_rd_data;

   enb_ram #(
      .WIDTH (2 * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (XW'(c_cur)),
      .rd_data (ram_rd_data)
   );

   // stage one: read data back, forward a same-column write still in flight
   logic               s1_valid_ff;
   logic               s1_int_ff, s1_bor_ff, s1_fwd_ff;
   logic [PIX_W-1:0]   s1_px_ff;
   logic [XW-1:0]      s1_col_ff;
   logic [YW-1:0]      s1_row_ff;
   logic [2*PIX_W-1:0] s1_fwd_data_ff;
   logic [PIX_W-1:0]   above, above2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_int_ff      <= is_interior;
         s1_bor_ff      <= is_border;
         s1_px_ff       <= req_data;
         s1_col_ff      <= XW'(c_cur);
         s1_row_ff      <= YW'(r_cur);
         s1_fwd_ff      <= s1_valid_ff && (s1_col_ff == XW'(c_cur));
         s1_fwd_data_ff <= ram_wr_data;
      end
   end

   always_comb begin
      if (s1_fwd_ff) begin
         above  = s1_fwd_data_ff[2*PIX_W-1:PIX_W];
         above2 = s1_fwd_data_ff[PIX_W-1:0];
      end else begin
         above  = ram_rd_data[2*PIX_W-1:PIX_W];
         above2 = ram_rd_data[PIX_W-1:0];
      end
      ram_wr_en   = s1_valid_ff;
      ram_wr_addr = s1_col_ff;
      ram_wr_data = {s1_px_ff, above};
   end

   // window shift, row 0 oldest, column 0 oldest
   logic [PIX_W-1:0] window_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) window_ff[k] <= '0;
      end else if (s1_valid_ff) begin
         window_ff[0] <= window_ff[1];
         window_ff[1] <= window_ff[2];
         window_ff[2] <= above2;
         window_ff[3] <= window_ff[4];
         window_ff[4] <= window_ff[5];
         window_ff[5] <= above;
         window_ff[6] <= window_ff[7];
         window_ff[7] <= window_ff[8];
         window_ff[8] <= s1_px_ff;
      end
   end

   // stage two: neighbor sums and result words
   logic             s2_valid_ff;
   logic             s2_int_ff, s2_bor_ff;
   logic [PIX_W-1:0] s2_px_ff;
   logic [XW-1:0]    s2_col_ff;
   logic [YW-1:0]    s2_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_int_ff <= s1_int_ff;
         s2_bor_ff <= s1_bor_ff;
         s2_px_ff  <= s1_px_ff;
         s2_col_ff <= s1_col_ff;
         s2_row_ff <= s1_row_ff;
      end
   end

   // sum of the eight neighbors of one channel, each divided by 8, centre skipped
   function automatic logic [CHAN_W-1:0] chan_sum(input logic [8:0][CHAN_W-1:0] v);
      logic [CHAN_W-1:0] s;
      s = '0;
      for (int k = 0; k < 9; k++) begin
         if (k != 4) s = s + CHAN_W'(v[k][CHAN_W-1:3]);
      end
      return s;
   endfunction

   logic [8:0][CHAN_W-1:0] win_r, win_g, win_b;
   rsp_type                blur_word, pass_word;
   enb_push_type           push;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         win_r[k] = window_ff[k][PIX_W-1:2*CHAN_W];
         win_g[k] = window_ff[k][2*CHAN_W-1:CHAN_W];
         win_b[k] = window_ff[k][CHAN_W-1:0];
      end
      blur_word.out_red     = chan_sum(win_r);
      blur_word.out_green   = chan_sum(win_g);
      blur_word.out_blue    = chan_sum(win_b);
      blur_word.out_row     = POS_W'(s2_row_ff - YW'(1));
      blur_word.out_col     = POS_W'(s2_col_ff - XW'(1));
      blur_word.last_of_run = !s2_bor_ff;
      pass_word.out_red     = s2_px_ff[PIX_W-1:2*CHAN_W];
      pass_word.out_green   = s2_px_ff[2*CHAN_W-1:CHAN_W];
      pass_word.out_blue    = s2_px_ff[CHAN_W-1:0];
      pass_word.out_row     = POS_W'(s2_row_ff);
      pass_word.out_col     = POS_W'(s2_col_ff);
      pass_word.last_of_run = 1'b1;
      push.num   = s2_valid_ff ? 2'(s2_int_ff) + 2'(s2_bor_ff) : 2'd0;
      push.word0 = s2_int_ff ? blur_word : pass_word;
      push.word1 = pass_word;
   end

   // result queue
   logic pop;

   assign pop = rsp_valid && !rsp_stall;

   enb_out_fifo #(
      .DEPTH (OUT_FIFO_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_word  (rsp_data)
   );

   // queue space reserved for words queued and in flight
   logic [QCW-1:0] used_ff, used_in;

   always_comb begin
      used_in = used_ff + QCW'(accept ? n_words : 2'd0) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   assign req_stall = reset || (used_ff > QCW'(OUT_FIFO_DEPTH - 2));

   // reservation never exceeds the queue
   assert property (@(posedge clock) disable iff (reset)
      used_ff <= QCW'(OUT_FIFO_DEPTH))
      else $error("result reservation beyond queue depth");

   // a word on the output is always covered by a reservation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (used_ff != '0))
      else $error("output word without reservation");

   // the column restarts after the last pixel of a row
   assert property (@(posedge clock) disable iff (reset)
      (accept && last_col) |=> (col_ff == '0))
      else $error("column did not restart at end of row");

   // a same-column access behind a pixel in stage one is always forwarded
   assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff && (s1_col_ff == XW'(c_cur))) |=> s1_fwd_ff)
      else $error("same-column access not forwarded");

endmodule
